>>> rtl/tlpt_pkg.sv
// shared constants and codes for the two-level page table engine
package tlpt_pkg;

  localparam int DEF_DIR_ENTRIES = 16;
  localparam int TBL_BITS        = 10;
  localparam int TBL_LEN         = 1024;
  localparam int DIR_BITS        = 10;
  localparam int OFS_BITS        = 12;
  localparam int FRAME_BITS      = 20;
  localparam int ENTRY_W         = 23;

  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] PAGE_BYTES = 32'h0000_1000;

  localparam logic [1:0] F_MAP  = 2'd0;
  localparam logic [1:0] F_XLT  = 2'd1;
  localparam logic [1:0] F_SRCH = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

endpackage

>>> rtl/tlpt_ram.sv
// generic single write port, single read port ram with registered read
module tlpt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tlpt_ctrl.sv
// sequencer for map, translate and search over the page entry ram
module tlpt_ctrl #(
  parameter int DIR_ENTRIES = tlpt_pkg::DEF_DIR_ENTRIES,
  parameter int ADDR_W      = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic [31:0]                  virt_addr,
  input  logic [31:0]                  phys_addr,
  input  logic [20:0]                  page_count,
  input  logic [31:0]                  search_size,
  input  logic                         writable,
  input  logic                         user_access,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [31:0]                  result_addr,
  output logic                         ram_we,
  output logic [ADDR_W-1:0]            ram_waddr,
  output logic [tlpt_pkg::ENTRY_W-1:0] ram_wdata,
  output logic [ADDR_W-1:0]            ram_raddr,
  input  logic [tlpt_pkg::ENTRY_W-1:0] ram_rdata
);
  import tlpt_pkg::*;

  localparam int DIR_W = ADDR_W - TBL_BITS;
  localparam logic [DIR_BITS:0] DIR_LIM = (DIR_BITS + 1)'(DIR_ENTRIES);
  localparam logic [32:0] SPACE_TOP = 33'h1_0000_0000;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAP  = 3'd1;
  localparam logic [2:0] S_CLR  = 3'd2;
  localparam logic [2:0] S_XLT  = 3'd3;
  localparam logic [2:0] S_SRCH = 3'd4;
  localparam logic [2:0] S_SCHK = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]          state;
  logic [DIR_ENTRIES-1:0] dir_present;
  logic [31:0]         cur_va;
  logic [31:0]         cur_pa;
  logic [20:0]         cnt;
  logic [1:0]          perm;
  logic [32:0]         srch_cur;
  logic [32:0]         srch_end;
  logic [TBL_BITS-1:0] clr_idx;
  logic [1:0]          res_status;
  logic [31:0]         res_addr;

  logic [DIR_BITS-1:0] in_dir, map_dir, srch_dir;
  logic                in_dir_ok, map_dir_ok, srch_dir_ok;
  logic [DIR_W-1:0]    in_dir_i, map_dir_i, srch_dir_i;
  logic [32:0]         end_sum;
  logic [32:0]         end_clamp;
  logic                rd_present;
  logic [FRAME_BITS-1:0] rd_frame;
  logic                out_free;

  assign in_dir      = virt_addr[31 -: DIR_BITS];
  assign map_dir     = cur_va[31 -: DIR_BITS];
  assign srch_dir    = srch_cur[31 -: DIR_BITS];
  assign in_dir_i    = in_dir[DIR_W-1:0];
  assign map_dir_i   = map_dir[DIR_W-1:0];
  assign srch_dir_i  = srch_dir[DIR_W-1:0];
  assign in_dir_ok   = {1'b0, in_dir} < DIR_LIM;
  assign map_dir_ok  = {1'b0, map_dir} < DIR_LIM;
  assign srch_dir_ok = {1'b0, srch_dir} < DIR_LIM;
  assign end_sum     = {1'b0, virt_addr} + {1'b0, search_size};
  assign end_clamp   = end_sum[32] ? SPACE_TOP : end_sum;
  assign rd_present  = ram_rdata[0];
  assign rd_frame    = ram_rdata[ENTRY_W-1 -: FRAME_BITS];
  assign out_free    = !out_valid || out_ready;
  assign in_ready    = (state == S_IDLE);

  always_comb begin
    ram_we    = (state == S_CLR) ||
                ((state == S_MAP) && map_dir_ok && dir_present[map_dir_i]);
    ram_waddr = (state == S_CLR) ? {map_dir_i, clr_idx}
                                 : {map_dir_i, cur_va[OFS_BITS +: TBL_BITS]};
    ram_wdata = (state == S_CLR) ? '0
                                 : {cur_pa[31 -: FRAME_BITS], perm, 1'b1};
    ram_raddr = (state == S_IDLE) ? {in_dir_i, virt_addr[OFS_BITS +: TBL_BITS]}
                                  : {srch_dir_i, srch_cur[OFS_BITS +: TBL_BITS]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      dir_present <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_va     <= virt_addr;
            cur_pa     <= phys_addr;
            cnt        <= page_count;
            perm       <= {user_access, writable};
            srch_cur   <= {1'b0, virt_addr};
            srch_end   <= end_clamp;
            res_addr   <= ALL_ONES;
            case (func)
              F_MAP: begin
                if (page_count == '0) begin
                  res_status <= ST_OK;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_MISS;
                  state      <= S_MAP;
                end
              end
              F_XLT: begin
                if (!in_dir_ok) begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end else if (!dir_present[in_dir_i]) begin
                  res_status <= ST_MISS;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_MISS;
                  state      <= S_XLT;
                end
              end
              F_SRCH: begin
                res_status <= ST_MISS;
                state      <= S_SRCH;
              end
              default: begin
                res_status <= ST_MISS;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_MAP: begin
          if (!map_dir_ok) begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end else if (!dir_present[map_dir_i]) begin
            clr_idx <= '0;
            state   <= S_CLR;
          end else begin
            cur_va <= cur_va + PAGE_BYTES;
            cur_pa <= cur_pa + PAGE_BYTES;
            cnt    <= cnt - 21'd1;
            if (cnt == 21'd1) begin
              res_status <= ST_OK;
              state      <= S_DONE;
            end
          end
        end
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == TBL_BITS'(TBL_LEN - 1)) begin
            dir_present[map_dir_i] <= 1'b1;
            state                  <= S_MAP;
          end
        end
        S_XLT: begin
          if (rd_present) begin
            res_status <= ST_OK;
            res_addr   <= {rd_frame, cur_va[OFS_BITS-1:0]};
          end
          state <= S_DONE;
        end
        S_SRCH: begin
          if (srch_cur >= srch_end) begin
            state <= S_DONE;
          end else if (!srch_dir_ok) begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end else if (!dir_present[srch_dir_i]) begin
            srch_cur <= srch_cur + {1'b0, PAGE_BYTES};
          end else begin
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (rd_present && (rd_frame == cur_pa[31 -: FRAME_BITS]) &&
              (srch_cur[OFS_BITS-1:0] == cur_pa[OFS_BITS-1:0])) begin
            res_status <= ST_OK;
            res_addr   <= srch_cur[31:0];
            state      <= S_DONE;
          end else begin
            srch_cur <= srch_cur + {1'b0, PAGE_BYTES};
            state    <= S_SRCH;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            result_addr <= res_addr;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/two_level_page_table_engine_top.sv
// top level of the two-level page table engine
// Holds the directory present bits in flops and all page tables in one ram
// (DIR_ENTRIES*1024 words of 23 bits) with one write and one registered read
// port. One word is handled at a time; that ram port sets the pace. Translate
// reads the page entry in its own state and then goes to the done state; when
// its directory entry is absent or out of range it goes straight to done. Map
// writes its pages in turn and stops with a range status on a directory index
// out of range. Each time a directory entry is first claimed, it is seen
// absent and then its table is zeroed one entry per cycle. Search steps
// through the pages and reads the page entry only where its directory entry
// is present. A finished result waits in the output register while the next
// word is accepted.
module two_level_page_table_engine_top #(
  parameter int DIR_ENTRIES = tlpt_pkg::DEF_DIR_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] virt_addr,
  input  logic [31:0] phys_addr,
  input  logic [20:0] page_count,
  input  logic [31:0] search_size,
  input  logic        writable,
  input  logic        user_access,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] result_addr
);
  import tlpt_pkg::*;

  localparam int DIR_W  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int ADDR_W = DIR_W + TBL_BITS;
  localparam int DEPTH  = DIR_ENTRIES * TBL_LEN;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  tlpt_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tlpt_ctrl #(
    .DIR_ENTRIES (DIR_ENTRIES),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .virt_addr   (virt_addr),
    .phys_addr   (phys_addr),
    .page_count  (page_count),
    .search_size (search_size),
    .writable    (writable),
    .user_access (user_access),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .result_addr (result_addr),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

endmodule

>>> sim/tb.sv
// testbench for the page table engine: a directed table, then random words against a predictor
`timescale 1ns / 100ps

module tb;
  import tlpt_pkg::*;

  localparam int          DIRS       = DEF_DIR_ENTRIES;
  localparam int          RAND_WORDS = 1130;
  localparam int          TAIL       = 40;
  localparam logic [1:0]  F_NONE     = 2'd3;

  typedef struct packed {
    logic        pinned;
    logic [1:0]  st;
    logic [31:0] addr;
    logic [1:0]  fn;
    logic [31:0] va;
    logic [31:0] pa;
    logic [20:0] cnt;
    logic [31:0] size;
    logic        wr;
    logic        us;
  } word_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] addr;
  } reply_t;

  localparam int PLAN_LEN = 24;
  // pinned rows carry the status and address typed in; the rest use the predictor
  localparam word_t PLAN [PLAN_LEN] = '{
    '{1, ST_MISS,  ALL_ONES, F_XLT,  32'h0000_0000, 32'h0, 0, 32'h0, 0, 0},
    '{1, ST_MISS,  ALL_ONES, F_SRCH, 32'h0000_0000, 32'h0, 0, 32'h0001_0000, 0, 0},
    '{1, ST_MISS,  ALL_ONES, F_SRCH, 32'h0000_0123, 32'h0, 0, 32'h0, 0, 0},
    '{1, ST_OK,    ALL_ONES, F_MAP,  32'h0000_0000, 32'h0, 0, 32'h0, 1, 1},
    '{1, ST_OK,    ALL_ONES, F_MAP,  32'h0000_0123, 32'h1234_5ABC, 4, 32'h0, 1, 0},
    '{0, ST_OK,    32'h0,    F_XLT,  32'h0000_1FFF, 32'h0, 0, 32'h0, 0, 0},
    '{0, ST_OK,    32'h0,    F_SRCH, 32'h0000_0ABC, 32'h1234_7ABC, 0, 32'h0000_4000, 0, 0},
    '{1, ST_RANGE, ALL_ONES, F_XLT,  32'hFFFF_FFFF, 32'h0, 0, 32'h0, 0, 0},
    '{1, ST_RANGE, ALL_ONES, F_XLT,  32'h0400_0000, 32'h0, 0, 32'h0, 0, 0},
    '{1, ST_RANGE, ALL_ONES, F_MAP,  32'h03FF_E000, 32'hFFFF_E000, 5, 32'h0, 1, 1},
    '{0, ST_OK,    32'h0,    F_XLT,  32'h03FF_F555, 32'h0, 0, 32'h0, 0, 0},
    '{1, ST_OK,    ALL_ONES, F_MAP,  32'h0000_0000, 32'hFFFF_F000, 2, 32'h0, 0, 1},
    '{0, ST_OK,    32'h0,    F_XLT,  32'h0000_1000, 32'h0, 0, 32'h0, 0, 0},
    '{1, ST_RANGE, ALL_ONES, F_SRCH, 32'hFFFF_F000, 32'h0, 0, 32'hFFFF_FFFF, 0, 0},
    '{0, ST_OK,    32'h0,    F_SRCH, 32'h03FF_F000, 32'h0, 0, 32'h0000_2000, 0, 0},
    '{1, ST_MISS,  ALL_ONES, F_NONE, 32'h5A5A_1234, 32'h0, 7, 32'h10, 1, 1},
    '{1, ST_RANGE, ALL_ONES, F_MAP,  32'h0200_0000, 32'h0200_0000, 21'h10_0000, 32'h0, 0, 0},
    '{0, ST_OK,    32'h0,    F_XLT,  32'h03FF_FFFF, 32'h0, 0, 32'h0, 0, 0},
    '{0, ST_OK,    32'h0,    F_SRCH, 32'h0200_0000, 32'h0300_0000, 0, 32'hFFFF_FFFF, 0, 0},
    '{0, ST_OK,    32'h0,    F_SRCH, 32'h0200_0000, ALL_ONES, 0, 32'hFFFF_FFFF, 0, 0},
    '{1, ST_OK,    ALL_ONES, F_MAP,  32'h0012_3456, 32'hABCD_E000, 1, 32'hFFFF_FFFF, 1, 1},
    '{1, ST_RANGE, ALL_ONES, F_SRCH, 32'hFFFF_E000, 32'h0, 0, 32'h0000_3000, 0, 0},
    '{1, ST_MISS,  ALL_ONES, F_NONE, ALL_ONES, ALL_ONES, 21'h1F_FFFF, ALL_ONES, 1, 1},
    '{0, ST_OK,    32'h0,    F_XLT,  32'h0012_3FFF, 32'h0, 0, 32'h0, 0, 0}
  };

  logic        clk;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [1:0]  func        = '0;
  logic [31:0] virt_addr   = '0;
  logic [31:0] phys_addr   = '0;
  logic [20:0] page_count  = '0;
  logic [31:0] search_size = '0;
  logic        writable    = 1'b0;
  logic        user_access = 1'b0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [1:0]  status;
  logic [31:0] result_addr;

  bit                 dir_live [DIRS];
  logic [ENTRY_W-1:0] pte      [DIRS*TBL_LEN];
  reply_t             pending  [$];
  bit                 calm       = 1'b0;
  int                 mismatches = 0;
  int                 results_seen = 0;
  int                 tally [4]  = '{0, 0, 0, 0};

  two_level_page_table_engine_top #(.DIR_ENTRIES(DIRS)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .virt_addr(virt_addr), .phys_addr(phys_addr),
    .page_count(page_count), .search_size(search_size),
    .writable(writable), .user_access(user_access),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .result_addr(result_addr)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void page_walk(input logic [31:0] va, output logic [1:0] st,
                                    output logic [31:0] pa);
    int unsigned        d;
    logic [ENTRY_W-1:0] e;
    d  = 32'(va[31:22]);
    pa = ALL_ONES;
    if (d >= DIRS) begin
      st = ST_RANGE;
    end else if (!dir_live[d]) begin
      st = ST_MISS;
    end else begin
      e = pte[d*TBL_LEN + va[21:12]];
      if (!e[0]) begin
        st = ST_MISS;
      end else begin
        st = ST_OK;
        pa = {e[22:3], va[11:0]};
      end
    end
  endfunction

  function automatic logic [1:0] map_run(input word_t w);
    logic [31:0] v;
    logic [31:0] p;
    int unsigned d;
    for (int unsigned i = 0; i < w.cnt; i++) begin
      v = w.va + i * PAGE_BYTES;
      p = w.pa + i * PAGE_BYTES;
      d = 32'(v[31:22]);
      if (d >= DIRS) return ST_RANGE;
      if (!dir_live[d]) begin
        for (int k = 0; k < TBL_LEN; k++) pte[d*TBL_LEN + k] = '0;
        dir_live[d] = 1'b1;
      end
      pte[d*TBL_LEN + v[21:12]] = {p[31:12], w.us, w.wr, 1'b1};
    end
    return ST_OK;
  endfunction

  function automatic void scan_range(input logic [31:0] va, input logic [31:0] size,
                                     input logic [31:0] target, output logic [1:0] st,
                                     output logic [31:0] addr);
    logic [32:0] cur;
    logic [32:0] stop;
    logic [1:0]  s;
    logic [31:0] p;
    st   = ST_MISS;
    addr = ALL_ONES;
    stop = {1'b0, va} + {1'b0, size};
    if (stop > 33'h1_0000_0000) stop = 33'h1_0000_0000;
    for (cur = {1'b0, va}; cur < stop; cur += {1'b0, PAGE_BYTES}) begin
      page_walk(cur[31:0], s, p);
      if (s == ST_RANGE) begin
        st = ST_RANGE;
        return;
      end
      if (s == ST_OK && p == target) begin
        st   = ST_OK;
        addr = cur[31:0];
        return;
      end
    end
  endfunction

  function automatic reply_t predict_reply(input word_t w);
    reply_t r;
    r.st   = ST_MISS;
    r.addr = ALL_ONES;
    case (w.fn)
      F_MAP:   r.st = map_run(w);
      F_XLT:   page_walk(w.va, r.st, r.addr);
      F_SRCH:  scan_range(w.va, w.size, w.pa, r.st, r.addr);
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pool_va();
    logic [9:0] d;
    logic [9:0] s;
    d = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(DIRS, 1023))
                                     : 10'($urandom_range(0, DIRS - 1));
    s = ($urandom_range(0, 4) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 15));
    return {d, s, 12'($urandom())};
  endfunction

  task automatic send_word(input word_t w);
    int unsigned gap;
    reply_t      r;
    gap = calm ? 0 : $urandom_range(0, 6);
    r   = predict_reply(w);
    if (w.pinned) begin
      r.st   = w.st;
      r.addr = w.addr;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= w.fn;
    virt_addr   <= w.va;
    phys_addr   <= w.pa;
    page_count  <= w.cnt;
    search_size <= w.size;
    writable    <= w.wr;
    user_access <= w.us;
    do @(posedge clk); while (!in_ready);
    pending.push_back(r);
    tally[w.fn]++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    reply_t r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending.size() == 0) begin
        report("unexpected word", {30'd0, status}, result_addr);
      end else begin
        r = pending.pop_front();
        if (status !== r.st) report("status", {30'd0, status}, {30'd0, r.st});
        if (result_addr !== r.addr) report("result_addr", result_addr, r.addr);
      end
    end
  end

  // result side stalls
  initial begin
    int unsigned stall;
    wait (rst == 1'b0);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    word_t       w;
    reply_t      probe;
    logic [31:0] va;
    int unsigned pick;
    int unsigned back;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) send_word(PLAN[i]);
    drain();

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n % 250 == 249) drain();
      pick     = $urandom_range(0, 99);
      w        = '0;
      w.wr     = 1'($urandom());
      w.us     = 1'($urandom());
      w.pa     = $urandom();
      w.size   = $urandom_range(0, 8) * PAGE_BYTES + 32'($urandom_range(0, 4095));
      if (pick < 35) begin
        w.fn  = F_MAP;
        w.va  = pool_va();
        w.cnt = ($urandom_range(0, 9) == 0) ? 21'($urandom_range(0, 300))
                                            : 21'($urandom_range(1, 8));
      end else if (pick < 65) begin
        w.fn = F_XLT;
        w.va = pool_va();
      end else if (pick < 85) begin
        // aim the search at a page that is mapped now
        w.fn  = F_SRCH;
        va    = pool_va();
        probe = predict_reply('{0, ST_OK, 32'h0, F_XLT, va, 32'h0, 0, 32'h0, 0, 0});
        if (probe.st == ST_OK) begin
          back = $urandom_range(0, 8);
          if (back > 32'(va[31:12])) back = 32'(va[31:12]);
          w.va   = va - back * PAGE_BYTES;
          w.pa   = probe.addr;
          w.size = back * PAGE_BYTES + 32'($urandom_range(1, 20480));
        end else begin
          w.va = va;
        end
      end else if (pick < 95) begin
        w.fn   = 2'($urandom_range(0, 3));
        w.va   = $urandom();
        w.cnt  = 21'($urandom());
        w.size = $urandom();
      end else begin
        w.fn  = F_NONE;
        w.va  = pool_va();
        w.cnt = 21'($urandom());
      end
      send_word(w);
    end

    drain();
    repeat (TAIL) @(posedge clk);
    $display("covered %0d map, %0d translate, %0d search and %0d unused-code words",
             tally[F_MAP], tally[F_XLT], tally[F_SRCH], tally[F_NONE]);
    $display("%0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tlpt_pkg.sv
rtl/tlpt_ram.sv
rtl/tlpt_ctrl.sv
rtl/two_level_page_table_engine_top.sv
sim/tb.sv
